[rtl/core/dqe_pkg.sv]
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types and constants of the deque with erase by value.
// ----------------------------------------------------------------------------
package dqe_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK     = 3'd0,
    CMD_POP_BACK      = 3'd1,
    CMD_SHIFT_FRONT   = 3'd2,
    CMD_UNSHIFT_FRONT = 3'd3,
    CMD_ERASE         = 3'd4
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

[rtl/core/dqe_req_if.sv]
// ----------------------------------------------------------------------------
// dqe_req_if
// Request channel: operation code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dqe_req_if
  import dqe_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

[rtl/core/dqe_rsp_if.sv]
// ----------------------------------------------------------------------------
// dqe_rsp_if
// Response channel: removed value, status and occupancy, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dqe_rsp_if
  import dqe_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STAT_W-1:0]        status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output data_out, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input data_out, input status, input occupancy,
                  output ready);
endinterface

[rtl/core/dqe_ctrl.sv]
// ----------------------------------------------------------------------------
// dqe_ctrl
// Controller: takes one item, runs it through the datapath, manages the
// result register valid flag.
// ----------------------------------------------------------------------------
module dqe_ctrl
  import dqe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_exec_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("result not flagged after execute");

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_no_exec_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> out_free)
    else $error("execute would overwrite a pending result");

endmodule

[rtl/core/dqe_datapath.sv]
// ----------------------------------------------------------------------------
// dqe_datapath
// Entry cells, fill count, request and result registers of the deque.
// ----------------------------------------------------------------------------
module dqe_datapath
  import dqe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [DATA_W-1:0] in_data,
  output logic signed [DATA_W-1:0] data_out,
  output logic [STAT_W-1:0]        status,
  output logic [OCC_W-1:0]         occupancy
);

  logic [CMD_W-1:0]  req_cmd;
  logic [DATA_W-1:0] req_data;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DATA_W-1:0] entries [DEPTH];
  logic [DATA_W-1:0] entries_next [DEPTH];
  logic [DATA_W-1:0] removed;
  status_t           stat_next;
  logic              full;
  logic              empty;
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  first;
  logic [DEPTH-1:0]  below;
  logic              found;
  logic [CNT_W-1:0]  last;
  logic [IDX_W-1:0]  last_idx;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign last     = count - CNT_W'(1);
  assign last_idx = last[IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CNT_W'(i) < count) && (entries[i] == req_data);
    end
  end

  // isolate lowest set bit, mark positions ahead of it
  assign first = match & (~match + DEPTH'(1));
  assign below = first - DEPTH'(1);
  assign found = |match;

  always_comb begin
    count_next = count;
    removed    = '0;
    stat_next  = STAT_OK;
    for (int i = 0; i < DEPTH; i++) entries_next[i] = entries[i];
    case (req_cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == count) entries_next[i] = req_data;
          end
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          removed    = entries[last_idx];
          count_next = last;
        end
      end
      CMD_SHIFT_FRONT: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          removed = entries[0];
          for (int i = 0; i < DEPTH - 1; i++) entries_next[i] = entries[i+1];
          count_next = last;
        end
      end
      CMD_UNSHIFT_FRONT: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          for (int i = 1; i < DEPTH; i++) entries_next[i] = entries[i-1];
          entries_next[0] = req_data;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_ERASE: begin
        if (!found) begin
          stat_next = STAT_NOT_FOUND;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (!below[i]) entries_next[i] = entries[i+1];
          end
          count_next = last;
        end
      end
      default: begin
        stat_next = STAT_OK;
      end
    endcase
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd  <= in_cmd;
      req_data <= in_data;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) entries[i] <= entries_next[i];
      data_out  <= removed;
      status    <= stat_next;
      occupancy <= occ_ext[OCC_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(count))
    else $error("fill count moved without an item");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (req_cmd == CMD_PUSH_BACK) && !full) |=>
    (count == $past(count) + CNT_W'(1)))
    else $error("push did not grow the fill count");

endmodule

[rtl/core/deque_with_erase_by_value_core.sv]
// ----------------------------------------------------------------------------
// deque_with_erase_by_value_core
// Bounded deque of signed 32-bit values with push/pop at both ends and erase
// of the first matching value.
// ----------------------------------------------------------------------------
// the item is held in the request register; the result is registered on execute
// a new item is accepted only when idle, after the previous item has executed
// a waiting result does not block the next accept; execute waits for it
// all cells are updated together on execute; erase compares every cell in parallel
// reset: synchronous, empties the deque; cell contents are not cleared
module deque_with_erase_by_value_core
  import dqe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dqe_req_if.sink   req,
  dqe_rsp_if.source rsp
);

  ctrl_cmd_t ctrl_cmd;

  dqe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (ctrl_cmd)
  );

  dqe_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctrl_cmd),
    .in_cmd    (req.cmd),
    .in_data   (req.data_in),
    .data_out  (rsp.data_out),
    .status    (rsp.status),
    .occupancy (rsp.occupancy)
  );

endmodule
